[hw/rtl/box_blur_line_filter_top_assert.svh]
// ----------------------------------------------------------------------------
// Box blur line filter - assertion macros
// Shared property forms used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_LINE_FILTER_TOP_ASSERT_SVH
`define BOX_BLUR_LINE_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define BBLF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBLF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bblf_pkg.sv]
// ----------------------------------------------------------------------------
// Box blur line filter - package
// Widths, register indexes and the controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none

package bblf_pkg;

    localparam int BBLF_MAX_RADIUS = 63;
    localparam int BBLF_MAX_LINE   = 4096;

    localparam int SAMPLE_W = 16;
    localparam int RADIUS_W = 6;
    localparam int INV_W    = 25;
    localparam int SUM_W    = 23;
    localparam int PROD_W   = SUM_W + INV_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = INV_W;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WINDOW = 1'd1;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 6'd1;
    localparam logic [INV_W-1:0]    INV_RST    = 25'd5592405;

    typedef struct packed {
        logic start;      // accept sample, write ring, read leaving sample
        logic add_main;   // update sum for the accepted sample
        logic mul;        // sum times reciprocal
        logic emit;       // round, saturate, load output register
        logic loop_read;  // flush: read leaving sample
        logic loop_add;   // flush: update sum, step position
        logic finish;     // advance or restart line position
    } t_dp_cmd;

    typedef struct packed {
        logic main_emit;
        logic fin;
        logic r_zero;
        logic loop_emit;
        logic loop_last;
        logic loop_done;
        logic slot_free;
    } t_dp_status;

endpackage

`default_nettype wire

[hw/rtl/bblf_if.sv]
// ----------------------------------------------------------------------------
// Box blur line filter - channel interfaces
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface bblf_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic        last;
    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface bblf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] blurred;
    logic        last_out;
    modport source (output valid, output blurred, output last_out, input ready);
    modport sink   (input valid, input blurred, input last_out, output ready);
endinterface

interface bblf_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [24:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/box_blur_line_filter_top.sv]
// ----------------------------------------------------------------------------
// Box blur line filter - top level
// Running-sum box blur over one line, clamped edges, reciprocal scaling.
// ----------------------------------------------------------------------------
//  Port     Dir  Payload                    Transaction
//  i_in     in   sample[15:0], last         valid & ready
//  o_out    out  blurred[15:0], last_out    valid & ready
//  i_cfg    in   index[0], data[24:0]       valid & ready (always ready)
//
//  A sample that produces an output passes through add, multiply and emit; one
//  that produces none goes from add straight to finish. The end-of-line flush
//  steps over r positions with a read and an add each, plus a multiply and emit
//  for each position that gives an output; the input is held until it is done.
//  The rate is set by the controller taking each sample through add, multiply
//  and emit in turn. Output is registered; emit waits while it is full and not
//  being taken. Synchronous active-low reset; ring contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_line_filter_top #(
    parameter int MAX_RADIUS = bblf_pkg::BBLF_MAX_RADIUS,
    parameter int MAX_LINE   = bblf_pkg::BBLF_MAX_LINE
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bblf_in_if.sink     i_in,
    bblf_out_if.source  o_out,
    bblf_cfg_if.sink    i_cfg
);
    import bblf_pkg::*;

    `include "box_blur_line_filter_top_assert.svh"

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       in_ready;
    logic [6:0] cmd_vec;

    bblf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    bblf_dp #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_LINE   (MAX_LINE)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_in.sample),
        .i_last   (i_in.last),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .o_out    (o_out),
        .i_cfg    (i_cfg)
    );

    assign i_in.ready = in_ready;
    assign cmd_vec    = dp_cmd;

    `BBLF_ASSERT_IMP(a_emit_slot_free, i_clk, i_rst_n, dp_cmd.emit,
        !o_out.valid || o_out.ready, "emit overwrote a pending result")
    `BBLF_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready,
        !i_in.ready, "input accepted while sample in progress")
    `BBLF_ASSERT_IMP(a_single_command, i_clk, i_rst_n, 1'b1,
        $onehot0(cmd_vec), "more than one datapath command")

endmodule

`default_nettype wire

[hw/rtl/bblf_ctrl.sv]
// ----------------------------------------------------------------------------
// Box blur line filter - controller
// Sequences the datapath through one sample and the end-of-line flush.
// ----------------------------------------------------------------------------
`default_nettype none

module bblf_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  bblf_pkg::t_dp_status  i_status,
    output bblf_pkg::t_dp_cmd     o_cmd
);
    import bblf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADD   = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_LREAD = 3'd4;
    localparam logic [2:0] S_LADD  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_flush, n_flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flush <= n_flush;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_flush    = r_flush;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_flush    = 1'b0;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add_main = 1'b1;
                if (i_status.main_emit) begin
                    n_state = S_MUL;
                end else if (i_status.fin) begin
                    // short line: every output comes from the flush
                    n_flush = 1'b1;
                    n_state = S_LREAD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (!r_flush) begin
                        if (i_status.fin && !i_status.r_zero) begin
                            n_flush = 1'b1;
                            n_state = S_LREAD;
                        end else begin
                            n_state = S_FIN;
                        end
                    end else begin
                        n_state = i_status.loop_done ? S_FIN : S_LREAD;
                    end
                end
            end
            S_LREAD: begin
                o_cmd.loop_read = 1'b1;
                n_state         = S_LADD;
            end
            S_LADD: begin
                o_cmd.loop_add = 1'b1;
                if (i_status.loop_emit) begin
                    n_state = S_MUL;
                end else if (i_status.loop_last) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_LREAD;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/bblf_dp.sv]
// ----------------------------------------------------------------------------
// Box blur line filter - datapath
// Sample ring, running sum, reciprocal scaling and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bblf_dp #(
    parameter int MAX_RADIUS = bblf_pkg::BBLF_MAX_RADIUS,
    parameter int MAX_LINE   = bblf_pkg::BBLF_MAX_LINE
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire [bblf_pkg::SAMPLE_W-1:0]   i_sample,
    input  wire                            i_last,
    input  bblf_pkg::t_dp_cmd              i_cmd,
    output bblf_pkg::t_dp_status           o_status,
    bblf_out_if.source                     o_out,
    bblf_cfg_if.sink                       i_cfg
);
    import bblf_pkg::*;

    localparam int RING_AW    = $clog2(2 * MAX_RADIUS + 2);
    localparam int RING_DEPTH = 1 << RING_AW;
    localparam int POS_W      = $clog2(MAX_LINE);
    localparam int CW         = POS_W + 8;

    localparam logic signed [CW-1:0] ONE_S = CW'(1);
    localparam logic [POS_W-1:0]     POS_END = POS_W'(MAX_LINE - 1);
    localparam logic [RADIUS_W-1:0]  RAD_CAP = RADIUS_W'(MAX_RADIUS);
    localparam logic [PROD_W:0]      ROUND_HALF = (PROD_W + 1)'(1) << 23;

    logic [SAMPLE_W-1:0] r_ring [RING_DEPTH];

    logic [RADIUS_W-1:0] r_radius;
    logic [INV_W-1:0]    r_inv;
    logic [POS_W-1:0]    r_pos;
    logic [SAMPLE_W-1:0] r_first;
    logic [SUM_W-1:0]    r_sum;
    logic                r_fin;
    logic                r_out_valid;

    logic [SAMPLE_W-1:0] r_s;
    logic signed [CW-1:0] r_c;
    logic [SAMPLE_W-1:0] r_rdata;
    logic                r_use_first;
    logic [PROD_W-1:0]   r_prod;
    logic                r_emit_last;
    logic [SAMPLE_W-1:0] r_blurred;
    logic                r_last_out;

    logic [RADIUS_W-1:0]  rad_eff;
    logic signed [CW-1:0] pos_s;
    logic signed [CW-1:0] rad_s;
    logic signed [CW-1:0] rd_k;
    logic [RING_AW-1:0]   rd_addr;
    logic [RING_AW-1:0]   wr_addr;
    logic [SAMPLE_W-1:0]  old_s;
    logic [SUM_W-1:0]     sum_step;
    logic [SUM_W-1:0]     sum_init;
    logic [PROD_W:0]      rounded_full;
    logic [23:0]          mean;

    assign rad_eff = (r_radius > RAD_CAP) ? RAD_CAP : r_radius;
    assign pos_s   = $signed({{(CW - POS_W){1'b0}}, r_pos});
    assign rad_s   = $signed({{(CW - RADIUS_W){1'b0}}, rad_eff});

    // leaving sample: p-2r-1 for a new sample, c-r-1 during the flush
    assign rd_k    = i_cmd.start ? (pos_s - (rad_s <<< 1) - ONE_S) : (r_c - rad_s - ONE_S);
    assign rd_addr = rd_k[RING_AW-1:0];
    assign wr_addr = pos_s[RING_AW-1:0];

    assign old_s    = r_use_first ? r_first : r_rdata;
    assign sum_step = r_sum + SUM_W'(r_s) - SUM_W'(old_s);
    assign sum_init = SUM_W'({rad_eff, 1'b1}) * SUM_W'(r_s);

    assign rounded_full = {1'b0, r_prod} + ROUND_HALF;
    assign mean         = rounded_full[47:24];

    // sample ring
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ring[wr_addr] <= i_sample;
        end
        if (i_cmd.start || i_cmd.loop_read) begin
            r_rdata     <= r_ring[rd_addr];
            r_use_first <= rd_k[CW-1] || (rd_k == '0);
        end
    end

    // control and line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= RADIUS_RST;
            r_inv       <= INV_RST;
            r_pos       <= '0;
            r_first     <= '0;
            r_sum       <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_RADIUS:     r_radius <= i_cfg.data[RADIUS_W-1:0];
                    REG_INV_WINDOW: r_inv    <= i_cfg.data[INV_W-1:0];
                endcase
            end
            if (i_cmd.start) begin
                // overlong line is cut at the last position
                r_fin <= i_last || (r_pos == POS_END);
            end
            if (i_cmd.add_main) begin
                if (r_pos == '0) begin
                    r_first <= r_s;
                    r_sum   <= sum_init;
                end else begin
                    r_sum <= sum_step;
                end
            end
            if (i_cmd.loop_add) begin
                r_sum <= sum_step;
            end
            if (i_cmd.finish) begin
                r_pos <= r_fin ? '0 : r_pos + POS_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_s <= i_sample;
        end
        if (i_cmd.add_main) begin
            r_c         <= pos_s - rad_s + ONE_S;
            r_emit_last <= r_fin && (rad_eff == '0);
        end
        if (i_cmd.loop_add) begin
            r_c         <= r_c + ONE_S;
            r_emit_last <= (r_c == pos_s);
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(r_inv);
        end
        if (i_cmd.emit) begin
            r_blurred  <= (mean > 24'd65535) ? 16'hFFFF : mean[SAMPLE_W-1:0];
            r_last_out <= r_emit_last;
        end
    end

    assign o_status.main_emit = (pos_s >= rad_s);
    assign o_status.fin       = r_fin;
    assign o_status.r_zero    = (rad_eff == '0);
    assign o_status.loop_emit = !r_c[CW-1];
    assign o_status.loop_last = (r_c == pos_s);
    assign o_status.loop_done = (r_c > pos_s);
    assign o_status.slot_free = !r_out_valid || o_out.ready;

    assign o_out.valid    = r_out_valid;
    assign o_out.blurred  = r_blurred;
    assign o_out.last_out = r_last_out;
    assign i_cfg.ready    = 1'b1;

endmodule

`default_nettype wire
